[sv/wavhps_pkg.sv]
`timescale 1ns / 1ps

package wavhps_pkg;

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE    = 2'd0;
    localparam logic [1:0] KIND_FORMAT_OK = 2'd1;
    localparam logic [1:0] KIND_INVALID   = 2'd2;
    localparam logic [1:0] KIND_TOO_SHORT = 2'd3;

    // Four-character codes, first character in the low byte
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;

    // Chunk length limits
    localparam logic [31:0] FMT_LEN_MIN  = 32'd16;
    localparam logic [31:0] FMT_LEN_MAX  = 32'd100;
    localparam logic [31:0] DATA_LEN_MIN = 32'd256;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_byte;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  amplitude;
        logic [31:0] sample_rate;
        logic [1:0]  channels;
        logic        sixteen_bit;
    } out_item_t;

    // Byte classification computed at the front
    typedef struct packed {
        logic is_zero;
        logic is_one;
        logic is_two;
        logic is_eight;
        logic is_sixteen;
        logic msb;
    } byte_class_t;

    // Queue entry between front and back
    typedef struct packed {
        logic [7:0]  file_byte;
        logic        last_byte;
        byte_class_t cls;
    } queue_item_t;

endpackage

[sv/wavhps_front.sv]
`timescale 1ns / 1ps

module wavhps_front (
    input  wavhps_pkg::in_item_t    in_item,
    output wavhps_pkg::queue_item_t q_item
);

    // Decode the byte values the parser tests against
    always_comb begin
        q_item.file_byte      = in_item.file_byte;
        q_item.last_byte      = in_item.last_byte;
        q_item.cls.is_zero    = (in_item.file_byte == 8'd0);
        q_item.cls.is_one     = (in_item.file_byte == 8'd1);
        q_item.cls.is_two     = (in_item.file_byte == 8'd2);
        q_item.cls.is_eight   = (in_item.file_byte == 8'd8);
        q_item.cls.is_sixteen = (in_item.file_byte == 8'd16);
        q_item.cls.msb        = in_item.file_byte[7];
    end

endmodule

[sv/wavhps_queue.sv]
`timescale 1ns / 1ps

module wavhps_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  wavhps_pkg::queue_item_t push_item,
    output logic                    full,
    input  logic                    pop,
    output logic                    not_empty,
    output wavhps_pkg::queue_item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_LAST   = PW'(DEPTH - 1);

    wavhps_pkg::queue_item_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == COUNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/wavhps_back.sv]
`timescale 1ns / 1ps

module wavhps_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_not_empty,
    input  wavhps_pkg::queue_item_t q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output wavhps_pkg::out_item_t   m_data
);

    typedef enum logic [5:0] {
        PH_HDR  = 6'b000001,
        PH_CHDR = 6'b000010,
        PH_FMT  = 6'b000100,
        PH_SKIP = 6'b001000,
        PH_PLAY = 6'b010000,
        PH_HALT = 6'b100000
    } phase_t;

    // Byte offsets inside the headers
    localparam logic [31:0] HDR_TAG_START = 32'd8;
    localparam logic [31:0] HDR_LEN       = 32'd12;
    localparam logic [31:0] CHDR_TAG_LEN  = 32'd4;
    localparam logic [31:0] CHDR_LEN      = 32'd8;
    localparam logic [3:0]  FMT_CODE_LO   = 4'd0;
    localparam logic [3:0]  FMT_CODE_HI   = 4'd1;
    localparam logic [3:0]  FMT_CHAN_LO   = 4'd2;
    localparam logic [3:0]  FMT_CHAN_HI   = 4'd3;
    localparam logic [3:0]  FMT_RATE_B0   = 4'd4;
    localparam logic [3:0]  FMT_RATE_B1   = 4'd5;
    localparam logic [3:0]  FMT_RATE_B2   = 4'd6;
    localparam logic [3:0]  FMT_RATE_B3   = 4'd7;
    localparam logic [3:0]  FMT_BITS_LO   = 4'd14;
    localparam logic [3:0]  FMT_BITS_HI   = 4'd15;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic        stereo_reg, stereo_next;
    logic        wide_reg, wide_next;
    logic [31:0] rate_reg, rate_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [1:0]  frame_reg, frame_next;

    logic                  m_valid_reg, m_valid_next;
    wavhps_pkg::out_item_t m_data_reg, m_data_next;

    logic        take;
    logic        res_hit;
    logic [1:0]  res_kind;
    logic [7:0]  res_amp;
    logic [31:0] count_inc;
    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic [31:0] fmt_rest;
    logic        fmt_bad;
    logic        fmt_done;
    logic [1:0]  frame_inc;
    logic [2:0]  frame_size;
    logic [7:0]  b;

    assign q_pop   = take;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign take    = q_not_empty && (!m_valid_reg || m_ready);

    assign b          = q_item.file_byte;
    assign count_inc  = count_reg + 32'd1;
    assign tag_shift  = {b, tag_reg[31:8]};
    assign len_shift  = {b, len_reg[31:8]};
    assign fmt_rest   = len_reg - wavhps_pkg::FMT_LEN_MIN;
    assign frame_inc  = frame_reg + 2'd1;
    assign frame_size = {wide_reg && stereo_reg, wide_reg ^ stereo_reg,
                         !wide_reg && !stereo_reg};

    // Parser state update for one byte
    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        stereo_next   = stereo_reg;
        wide_next     = wide_reg;
        rate_next     = rate_reg;
        fmt_seen_next = fmt_seen_reg;
        frame_next    = frame_reg;
        res_hit       = 1'b0;
        res_kind      = wavhps_pkg::KIND_INVALID;
        res_amp       = 8'd0;
        fmt_bad       = 1'b0;
        fmt_done      = 1'b0;

        case (phase_reg)
            PH_HDR: begin
                if (count_reg >= HDR_TAG_START) begin
                    tag_next = tag_shift;
                end
                count_next = count_inc;
                if (count_inc == HDR_LEN) begin
                    count_next = 32'd0;
                    if (tag_shift == wavhps_pkg::TAG_WAVE) begin
                        phase_next = PH_CHDR;
                    end else begin
                        res_hit    = 1'b1;
                        phase_next = PH_HALT;
                    end
                end
            end
            PH_CHDR: begin
                if (count_reg < CHDR_TAG_LEN) begin
                    tag_next = tag_shift;
                end else begin
                    len_next = len_shift;
                end
                count_next = count_inc;
                // Chunk header complete: decide by id and length
                if (count_inc == CHDR_LEN) begin
                    count_next = 32'd0;
                    if (tag_reg == wavhps_pkg::TAG_FMT) begin
                        if (len_shift < wavhps_pkg::FMT_LEN_MIN ||
                            len_shift > wavhps_pkg::FMT_LEN_MAX) begin
                            res_hit    = 1'b1;
                            phase_next = PH_HALT;
                        end else begin
                            phase_next = PH_FMT;
                        end
                    end else if (tag_reg == wavhps_pkg::TAG_DATA) begin
                        if (!fmt_seen_reg) begin
                            res_hit    = 1'b1;
                            phase_next = PH_HALT;
                        end else if (len_shift < wavhps_pkg::DATA_LEN_MIN) begin
                            res_hit    = 1'b1;
                            res_kind   = wavhps_pkg::KIND_TOO_SHORT;
                            phase_next = PH_HALT;
                        end else begin
                            frame_next = 2'd0;
                            phase_next = PH_PLAY;
                        end
                    end else if (tag_reg == wavhps_pkg::TAG_LIST ||
                                 tag_reg == wavhps_pkg::TAG_FACT) begin
                        if (len_shift == 32'd0) begin
                            phase_next = PH_CHDR;
                        end else begin
                            count_next = len_shift;
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        res_hit    = 1'b1;
                        phase_next = PH_HALT;
                    end
                end
            end
            PH_FMT: begin
                case (count_reg[3:0])
                    FMT_CODE_LO: fmt_bad = !q_item.cls.is_one;
                    FMT_CODE_HI: fmt_bad = !q_item.cls.is_zero;
                    FMT_CHAN_LO: begin
                        fmt_bad     = !(q_item.cls.is_one || q_item.cls.is_two);
                        stereo_next = q_item.cls.is_two;
                    end
                    FMT_CHAN_HI: fmt_bad = !q_item.cls.is_zero;
                    FMT_RATE_B0, FMT_RATE_B1, FMT_RATE_B2, FMT_RATE_B3: begin
                        rate_next = {b, rate_reg[31:8]};
                    end
                    FMT_BITS_LO: begin
                        fmt_bad   = !(q_item.cls.is_eight || q_item.cls.is_sixteen);
                        wide_next = q_item.cls.is_sixteen;
                    end
                    FMT_BITS_HI: begin
                        fmt_bad  = !q_item.cls.is_zero;
                        fmt_done = q_item.cls.is_zero;
                    end
                    default: begin
                    end
                endcase
                count_next = count_inc;
                if (fmt_bad) begin
                    res_hit    = 1'b1;
                    phase_next = PH_HALT;
                end else if (fmt_done) begin
                    res_hit       = 1'b1;
                    res_kind      = wavhps_pkg::KIND_FORMAT_OK;
                    fmt_seen_next = 1'b1;
                    // Skip any extension bytes past the basic 16
                    if (fmt_rest == 32'd0) begin
                        count_next = 32'd0;
                        phase_next = PH_CHDR;
                    end else begin
                        count_next = fmt_rest;
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                count_next = count_reg - 32'd1;
                if (count_reg == 32'd1) begin
                    phase_next = PH_CHDR;
                end
            end
            PH_PLAY: begin
                // Left channel: byte 0 of an 8-bit frame, byte 1 of a 16-bit one
                if (frame_reg == {1'b0, wide_reg}) begin
                    res_hit  = 1'b1;
                    res_kind = wavhps_pkg::KIND_SAMPLE;
                    res_amp  = (wide_reg && q_item.cls.msb) ? 8'd0 : b;
                end
                frame_next = ({1'b0, frame_inc} >= frame_size) ? 2'd0 : frame_inc;
            end
            default: begin
            end
        endcase

        // Final byte: report an unfinished header, then start over
        if (q_item.last_byte) begin
            if (!res_hit && (phase_next == PH_HDR || phase_next == PH_CHDR ||
                             phase_next == PH_FMT || phase_next == PH_SKIP)) begin
                res_hit  = 1'b1;
                res_kind = wavhps_pkg::KIND_INVALID;
            end
            phase_next    = PH_HDR;
            count_next    = 32'd0;
            tag_next      = 32'd0;
            len_next      = 32'd0;
            stereo_next   = 1'b0;
            wide_next     = 1'b0;
            rate_next     = 32'd0;
            fmt_seen_next = 1'b0;
            frame_next    = 2'd0;
        end
    end

    // Output register; format fields come from the updated state
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take && res_hit) begin
            m_valid_next            = 1'b1;
            m_data_next.result_kind = res_kind;
            m_data_next.amplitude   = res_amp;
            m_data_next.sample_rate = 32'd0;
            m_data_next.channels    = 2'd0;
            m_data_next.sixteen_bit = 1'b0;
            if (res_kind == wavhps_pkg::KIND_FORMAT_OK) begin
                m_data_next.sample_rate = rate_next;
                m_data_next.channels    = stereo_next ? 2'd2 : 2'd1;
                m_data_next.sixteen_bit = wide_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR;
            count_reg    <= 32'd0;
            tag_reg      <= 32'd0;
            len_reg      <= 32'd0;
            stereo_reg   <= 1'b0;
            wide_reg     <= 1'b0;
            rate_reg     <= 32'd0;
            fmt_seen_reg <= 1'b0;
            frame_reg    <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                tag_reg      <= tag_next;
                len_reg      <= len_next;
                stereo_reg   <= stereo_next;
                wide_reg     <= wide_next;
                rate_reg     <= rate_next;
                fmt_seen_reg <= fmt_seen_next;
                frame_reg    <= frame_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

[sv/wav_header_parse_sample_extract_unit.sv]
`timescale 1ns / 1ps

// Channel   Ports                        Payload
// input     s_valid, s_ready, s_data     file_byte, last_byte
// result    m_valid, m_ready, m_data     result_kind, amplitude, sample_rate,
//                                        channels, sixteen_bit
//
// One byte per cycle sustained while results are taken; m_valid for a byte's
// result rises after the queue write, then the parser's output register.
// The parser consumes one queued byte per cycle whenever its output register
// is empty or being taken; a result stall holds the parser and backs up the
// queue, and s_ready drops once the queue is full.
// aresetn is synchronous, active low; the parser restarts at the file header.

module wav_header_parse_sample_extract_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wavhps_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wavhps_pkg::out_item_t m_data
);

    wavhps_pkg::queue_item_t front_item;
    wavhps_pkg::queue_item_t back_item;
    logic                    q_full;
    logic                    q_not_empty;
    logic                    q_pop;

    assign s_ready = !q_full;

    // Front: classify incoming byte
    wavhps_front u_front (
        .in_item (s_data),
        .q_item  (front_item)
    );

    // Queue decoupling intake from the parser
    wavhps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (back_item)
    );

    // Back: header parser and sample extractor
    wavhps_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (back_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
